### rtl/smmv_pkg.sv
// ----------------------------------------------------------------------------
// smmv_pkg
// Shared widths, defaults and stream field offsets for the sample
// min/max/mean/variance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smmv_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int FRAC_W        = 16;
  localparam int AVG_W         = 32;
  localparam int SPREAD_W      = 46;
  localparam int CNT_OUT_W     = 11;
  localparam int MAX_COUNT_DEF = 1024;

  // Slave-side tdata: sample only, end of run travels on tlast
  localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // Master-side tdata layout, lowest bit first
  localparam int LARGEST_LSB  = 0;
  localparam int SMALLEST_LSB = LARGEST_LSB + SAMPLE_W;
  localparam int AVG_LSB      = SMALLEST_LSB + SAMPLE_W;
  localparam int SPREAD_LSB   = AVG_LSB + AVG_W;
  localparam int CNT_LSB      = SPREAD_LSB + SPREAD_W;
  localparam int OVF_LSB      = CNT_LSB + CNT_OUT_W;
  localparam int M_FIELDS_W   = OVF_LSB + 1;
  localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W      = M_TDATA_W - M_FIELDS_W;

endpackage

`default_nettype wire

### rtl/smmv_mul.sv
// ----------------------------------------------------------------------------
// smmv_mul
// Shared shift-add multiplier: one multiplier bit per cycle, stops as soon
// as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smmv_mul #(
  parameter int A_W = 41,
  parameter int B_W = 27
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [A_W-1:0]       a_i,
  input  wire logic [B_W-1:0]       b_i,
  output logic                      done_o,
  output logic [A_W+B_W-1:0]        prod_o
);

  localparam int P_W = A_W + B_W;

  logic           busy_q;
  logic [P_W-1:0] acc_q;
  logic [P_W-1:0] a_q;
  logic [B_W-1:0] b_q;
  logic           b_zero;

  assign b_zero = (b_q == '0);
  assign done_o = busy_q && b_zero;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && b_zero) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= P_W'(a_i);
      b_q   <= b_i;
    end else if (busy_q && !b_zero) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[P_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

### rtl/smmv_div.sv
// ----------------------------------------------------------------------------
// smmv_div
// Restoring unsigned divider: one quotient bit per cycle, N_W steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smmv_div #(
  parameter int N_W = 68,
  parameter int D_W = 22
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] dividend_i,
  input  wire logic [D_W-1:0] divisor_i,
  output logic                done_o,
  output logic [N_W-1:0]      quotient_o,
  output logic [D_W-1:0]      remainder_o
);

  localparam int STEP_W = $clog2(N_W + 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [N_W-1:0]    quo_q;
  logic [D_W-1:0]    rem_q;
  logic [D_W-1:0]    dvs_q;
  logic [D_W:0]      trial;
  logic [D_W:0]      trial_sub;
  logic              fits;
  logic              stepping;

  assign trial     = {rem_q, quo_q[N_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = (trial >= {1'b0, dvs_q});
  assign stepping  = busy_q && (step_q != '0);

  assign done_o      = busy_q && (step_q == '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(N_W);
    end else if (stepping) begin
      step_q <= step_q - 1'b1;
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (stepping) begin
      rem_q <= fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
      quo_q <= {quo_q[N_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/sample_min_max_mean_variance_unit.sv
// Per sample: each accepted sample is squared on the shared shift-add multiplier;
// a dropped sample skips the multiply.
// End of run: three more multiplies, two divisions on the restoring divider and
// one output load.
// Reset: asynchronous, active low; clears the run and drops any pending result.
// ----------------------------------------------------------------------------
// sample_min_max_mean_variance_unit
// Accumulates a run of signed samples and reports max, min, mean and
// population variance at the end of each run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_min_max_mean_variance_unit
  import smmv_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] sample
  input  wire logic                 s_axis_tlast,   // last
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata    // [15:0] largest, [31:16] smallest,
                                                    // [63:32] average, [109:64] spread,
                                                    // [120:110] sample_count,
                                                    // [121] overflowed, rest zero
);

  localparam int CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int DIFF_W = CNT_W + SQ_W;
  localparam int MA_W   = SQ_W;
  localparam int MB_W   = SUM_W;
  localparam int MP_W   = MA_W + MB_W;
  localparam int DN_W   = DIFF_W + FRAC_W;
  localparam int DD_W   = 2 * CNT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_NSQ   = 3'd2;
  localparam logic [2:0] ST_MAG2  = 3'd3;
  localparam logic [2:0] ST_NN    = 3'd4;
  localparam logic [2:0] ST_DVAR  = 3'd5;
  localparam logic [2:0] ST_DMEAN = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

  logic [2:0]                  state_q, state_d;
  logic                        go_q, go_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic signed [SAMPLE_W-1:0]  max_q, max_d;
  logic signed [SAMPLE_W-1:0]  min_q, min_d;
  logic signed [SUM_W-1:0]     sum_q, sum_d;
  logic [SQ_W-1:0]             sumsq_q, sumsq_d;
  logic                        dropped_q, dropped_d;
  logic                        m_valid_q, m_valid_d;

  logic signed [SAMPLE_W-1:0]  sample_q;
  logic                        last_q;
  logic [DIFF_W-1:0]           t1_q;
  logic [DIFF_W-1:0]           diff_q;
  logic [DD_W-1:0]             n2_q;
  logic [SPREAD_W-1:0]         spread_q;
  logic [AVG_W-1:0]            avg_q;
  logic [M_TDATA_W-1:0]        m_data_q;

  logic                        s_xfer;
  logic                        load_out;
  logic                        room;
  logic [SAMPLE_W-1:0]         abs_s;
  logic                        sum_neg;
  logic [SUM_W-1:0]            mag;
  logic [MP_W-1:0]             t1_ext;
  logic [DIFF_W-1:0]           diff_new;
  logic [AVG_W-1:0]            quo_lo;
  logic [AVG_W-1:0]            mean_new;
  logic [CNT_OUT_W+CNT_W-1:0]  cnt_ext;
  logic [M_TDATA_W-1:0]        m_data_new;

  logic                        mul_start, mul_done;
  logic [MA_W-1:0]             mul_a;
  logic [MB_W-1:0]             mul_b;
  logic [MP_W-1:0]             mul_prod;
  logic                        div_start, div_done;
  logic [DN_W-1:0]             div_n;
  logic [DD_W-1:0]             div_d;
  logic [DN_W-1:0]             div_quo;
  logic [DD_W-1:0]             div_rem;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign room          = (count_q < CNT_W'(MAX_COUNT));
  assign load_out      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  assign abs_s   = sample_q[SAMPLE_W-1] ? SAMPLE_W'(-sample_q) : SAMPLE_W'(sample_q);
  assign sum_neg = sum_q[SUM_W-1];
  assign mag     = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Clamp at zero like an unsigned subtract that would underflow
  assign t1_ext   = MP_W'(t1_q);
  assign diff_new = (t1_ext >= mul_prod) ? DIFF_W'(t1_ext - mul_prod) : '0;

  // Floor of a negative mean: round the magnitude up
  assign quo_lo   = div_quo[AVG_W-1:0];
  assign mean_new = sum_neg ? AVG_W'(-(quo_lo + AVG_W'(div_rem != '0))) : quo_lo;

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_q};
  assign m_data_new = {{M_PAD_W{1'b0}}, dropped_q, cnt_ext[CNT_OUT_W-1:0], spread_q, avg_q,
                       min_q, max_q};

  // Operand select for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (state_q)
      ST_SQR: begin
        mul_a = MA_W'(abs_s);
        mul_b = MB_W'(abs_s);
      end
      ST_NSQ: begin
        mul_a = sumsq_q;
        mul_b = MB_W'(count_q);
      end
      ST_MAG2: begin
        mul_a = MA_W'(mag);
        mul_b = mag;
      end
      ST_NN: begin
        mul_a = MA_W'(count_q);
        mul_b = MB_W'(count_q);
      end
      ST_DVAR: begin
        div_n = {diff_q, {FRAC_W{1'b0}}};
        div_d = n2_q;
      end
      ST_DMEAN: begin
        div_n = DN_W'({mag, {FRAC_W{1'b0}}});
        div_d = DD_W'(count_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_start = go_q && ((state_q == ST_SQR) || (state_q == ST_NSQ) ||
                              (state_q == ST_MAG2) || (state_q == ST_NN));
  assign div_start = go_q && ((state_q == ST_DVAR) || (state_q == ST_DMEAN));

  always_comb begin
    state_d   = state_q;
    go_d      = 1'b0;
    count_d   = count_q;
    max_d     = max_q;
    min_d     = min_q;
    sum_d     = sum_q;
    sumsq_d   = sumsq_q;
    dropped_d = dropped_q;
    m_valid_d = m_valid_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          if (room) begin
            state_d = ST_SQR;
            go_d    = 1'b1;
          end else begin
            dropped_d = 1'b1;
            if (s_axis_tlast) begin
              state_d = ST_NSQ;
              go_d    = 1'b1;
            end
          end
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          count_d = count_q + 1'b1;
          if (sample_q > max_q) begin
            max_d = sample_q;
          end
          if (sample_q < min_q) begin
            min_d = sample_q;
          end
          sum_d   = sum_q + SUM_W'(sample_q);
          sumsq_d = sumsq_q + mul_prod[SQ_W-1:0];
          state_d = last_q ? ST_NSQ : ST_IDLE;
          go_d    = last_q;
        end
      end
      ST_NSQ: begin
        if (mul_done) begin
          state_d = ST_MAG2;
          go_d    = 1'b1;
        end
      end
      ST_MAG2: begin
        if (mul_done) begin
          state_d = ST_NN;
          go_d    = 1'b1;
        end
      end
      ST_NN: begin
        if (mul_done) begin
          state_d = ST_DVAR;
          go_d    = 1'b1;
        end
      end
      ST_DVAR: begin
        if (div_done) begin
          state_d = ST_DMEAN;
          go_d    = 1'b1;
        end
      end
      ST_DMEAN: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          // Hand the result over and start a fresh run
          m_valid_d = 1'b1;
          count_d   = '0;
          max_d     = MOST_NEG;
          min_d     = MOST_POS;
          sum_d     = '0;
          sumsq_d   = '0;
          dropped_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      count_q   <= '0;
      max_q     <= MOST_NEG;
      min_q     <= MOST_POS;
      sum_q     <= '0;
      sumsq_q   <= '0;
      dropped_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      go_q      <= go_d;
      count_q   <= count_d;
      max_q     <= max_d;
      min_q     <= min_d;
      sum_q     <= sum_d;
      sumsq_q   <= sumsq_d;
      dropped_q <= dropped_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      last_q   <= s_axis_tlast;
    end
    if ((state_q == ST_NSQ) && mul_done) begin
      t1_q <= mul_prod[DIFF_W-1:0];
    end
    if ((state_q == ST_MAG2) && mul_done) begin
      diff_q <= diff_new;
    end
    if ((state_q == ST_NN) && mul_done) begin
      n2_q <= mul_prod[DD_W-1:0];
    end
    if ((state_q == ST_DVAR) && div_done) begin
      spread_q <= div_quo[SPREAD_W-1:0];
    end
    if ((state_q == ST_DMEAN) && div_done) begin
      avg_q <= mean_new;
    end
    if (load_out) begin
      m_data_q <= m_data_new;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  smmv_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  smmv_div #(
    .N_W (DN_W),
    .D_W (DD_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_n),
    .divisor_i   (div_d),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

endmodule

`default_nettype wire

### rtl/smmv_checker.sv
// ----------------------------------------------------------------------------
// smmv_checker
// Port-level checks on the sample min/max/mean/variance unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smmv_checker
  import smmv_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tlast,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic signed [SAMPLE_W-1:0] largest;
  logic signed [SAMPLE_W-1:0] smallest;

  assign largest  = m_axis_tdata[LARGEST_LSB +: SAMPLE_W];
  assign smallest = m_axis_tdata[SMALLEST_LSB +: SAMPLE_W];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed or vanished while stalled");

  // End of run must stop intake while the result is worked out
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after end-of-run transfer");

  // Every run has at least one sample, so max never falls below min
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (largest >= smallest))
    else $error("largest below smallest in result");

  // A new result only appears out of a busy cycle
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without end-of-run processing");

endmodule

bind sample_min_max_mean_variance_unit smmv_checker u_smmv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample min/max/mean/variance unit. Runs of
// signed samples are streamed in with random gaps and output stalls; a
// scoreboard folds every accepted sample into its own running statistics
// and compares each end-of-run summary field by field.
// ----------------------------------------------------------------------------

module tb;
  import smmv_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 300;
  localparam int IDLE_PCT    = 37;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    logic signed [SAMPLE_W-1:0]  largest;
    logic signed [SAMPLE_W-1:0]  smallest;
    logic signed [AVG_W-1:0]     average;
    logic        [SPREAD_W-1:0]  spread;
    logic        [CNT_OUT_W-1:0] sample_count;
    logic                        overflowed;
  } run_summary_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // running statistics of the run in flight
  int unsigned     acc_count;
  int              acc_max;
  int              acc_min;
  longint          acc_sum;
  longint unsigned acc_sq;
  bit              acc_dropped;

  run_summary_t pending_summaries[$];

  int  mismatches = 0;
  int  samples_in = 0;
  int  runs_out = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_kick = 1'b0;
  bit  steady = 1'b0;

  sample_min_max_mean_variance_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic void clear_stats();
    acc_count   = 0;
    acc_max     = -32768;
    acc_min     = 32767;
    acc_sum     = 0;
    acc_sq      = 0;
    acc_dropped = 1'b0;
  endfunction

  // Fold one accepted sample in; on the last one, queue the run summary.
  function automatic void fold_sample(logic signed [SAMPLE_W-1:0] v, logic lst);
    run_summary_t    r;
    longint unsigned n;
    longint unsigned n2;
    longint unsigned mag;
    longint unsigned diff;
    longint unsigned var_q;
    longint          mean_q;
    if (acc_count < MAX_COUNT_DEF) begin
      acc_count++;
      if (int'(v) > acc_max) acc_max = int'(v);
      if (int'(v) < acc_min) acc_min = int'(v);
      acc_sum += longint'(v);
      acc_sq  += longint'(v) * longint'(v);
    end else begin
      acc_dropped = 1'b1;
    end
    if (!lst) return;
    n      = acc_count;
    n2     = n * n;
    mean_q = 0;
    var_q  = 0;
    if (n != 0) begin
      mag = (acc_sum < 0) ? longint'(-acc_sum) : longint'(acc_sum);
      // floor toward minus infinity: round the magnitude up when negative
      if (acc_sum < 0) mean_q = -longint'(((mag << FRAC_W) + n - 1) / n);
      else             mean_q = longint'((mag << FRAC_W) / n);
      diff = n * acc_sq;
      diff = (diff >= mag * mag) ? diff - mag * mag : 0;
      var_q = ((diff / n2) << FRAC_W) + (((diff % n2) << FRAC_W) / n2);
    end
    r.largest      = acc_max[SAMPLE_W-1:0];
    r.smallest     = acc_min[SAMPLE_W-1:0];
    r.average      = mean_q[AVG_W-1:0];
    r.spread       = var_q[SPREAD_W-1:0];
    r.sample_count = acc_count[CNT_OUT_W-1:0];
    r.overflowed   = acc_dropped;
    pending_summaries.push_back(r);
    clear_stats();
  endfunction

  function automatic void check_field(string fname, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH run %0d %s: expected %0h, got %0h", runs_out, fname,
                 exp_v, act_v);
    end
  endfunction

  // Scoreboard: feed accepted samples to the predictor, check each summary.
  always @(posedge clk_i) begin
    run_summary_t r;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        fold_sample(s_tdata[SAMPLE_W-1:0], s_tlast);
        samples_in++;
      end
      if (m_tvalid && m_tready) begin
        runs_out++;
        if (pending_summaries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("MISMATCH unexpected summary %0h", m_tdata);
        end else begin
          r = pending_summaries.pop_front();
          // compare raw field bits, so keep signed fields from sign-extending
          check_field("largest", $unsigned(r.largest), m_tdata[LARGEST_LSB +: SAMPLE_W]);
          check_field("smallest", $unsigned(r.smallest),
                      m_tdata[SMALLEST_LSB +: SAMPLE_W]);
          check_field("average", $unsigned(r.average), m_tdata[AVG_LSB +: AVG_W]);
          check_field("spread", r.spread, m_tdata[SPREAD_LSB +: SPREAD_W]);
          check_field("sample_count", r.sample_count, m_tdata[CNT_LSB +: CNT_OUT_W]);
          check_field("overflowed", r.overflowed, m_tdata[OVF_LSB]);
        end
      end
    end
  end

  // Output side: random stalls, or a counted hold-off when kicked.
  always @(negedge clk_i) begin
    if (hold_kick) begin
      hold_left = HOLD_CYCLES;
      hold_kick = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one sample; tvalid stays high on return so back-to-back transfers
  // need no extra edge.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] v, input logic lst);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(v);
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0:       return SAMPLE_W'($urandom_range(16)) - 16'sd8;
      1:       return $urandom_range(1) ? 16'sh7fff - SAMPLE_W'($urandom_range(3))
                                        : 16'sh8000 + SAMPLE_W'($urandom_range(3));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_single_sample_runs();
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sd0, 1'b1);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sd1, 1'b1);
  endtask

  task automatic test_short_runs();
    // mean of minus one half floors to minus one half exactly; minus a third
    // must round down
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd0, 1'b1);
    push_sample(-16'sd3, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd1, 1'b1);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    for (int i = 0; i < 3; i++) push_sample(16'sh8000, i == 2);
    for (int i = 1; i <= 7; i++) push_sample(SAMPLE_W'(i), i == 7);
    drain_results();
  endtask

  task automatic test_full_length_run();
    for (int i = 1; i <= MAX_COUNT_DEF; i++) push_sample(16'sh8000, i == MAX_COUNT_DEF);
    drain_results();
  endtask

  task automatic test_overlong_run();
    // the last mark lands on a dropped sample
    for (int i = 1; i <= MAX_COUNT_DEF + 6; i++)
      push_sample(i[0] ? 16'sh7fff : 16'sh8000, i == MAX_COUNT_DEF + 6);
    drain_results();
  endtask

  task automatic test_output_hold_off();
    @(posedge clk_i);
    hold_kick = 1'b1;
    for (int run = 0; run < 6; run++)
      for (int i = 0; i < 3; i++) push_sample(pick_sample(), i == 2);
    drain_results();
  endtask

  task automatic test_random_runs();
    int sent;
    int len;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      steady = (sent >= 250 && sent < 400);
      for (int i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
      sent += len;
      if (!paused && sent >= 450) begin
        drain_results();
        paused = 1'b1;
      end
    end
    steady = 1'b0;
    drain_results();
  endtask

  initial begin
    clear_stats();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_single_sample_runs();
    test_short_runs();
    test_full_length_run();
    test_overlong_run();
    test_output_hold_off();
    test_random_runs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_summaries.size() != 0) begin
      mismatches++;
      $display("MISMATCH %0d summaries never arrived", pending_summaries.size());
    end
    $display("Streamed %0d samples in %0d runs: extremes, a full-length and an",
             samples_in, runs_out);
    $display("overlong run, a long output hold-off and random gaps; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sample_min_max_mean_variance_unit.f
rtl/smmv_pkg.sv
rtl/smmv_mul.sv
rtl/smmv_div.sv
rtl/sample_min_max_mean_variance_unit.sv
rtl/smmv_checker.sv
verif/tb.sv
